// ----- rtl/signed_int_to_radix_digits_assert.svh -----
// Assertion macros shared by the radix digit converter RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sird: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SIRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sird: next-cycle check failed");

`endif

// ----- rtl/sird_pkg.sv -----
// Shared types and constants for the signed integer to radix digit converter.
// No dependencies.
package sird_pkg;

    localparam int DEF_MAX_RADIX = 16;
    localparam int MAX_DIGITS    = 32;
    localparam int STACK_AW      = $clog2(MAX_DIGITS);
    localparam int CNT_W         = STACK_AW + 1;
    localparam int DIV_STEPS     = 8;   // four quotient bits per cycle
    localparam int DIV_SW        = $clog2(DIV_STEPS);

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // configuration register indexes
    localparam logic [1:0] CFG_RADIX     = 2'd0;
    localparam logic [1:0] CFG_DIGITS_LO = 2'd1;
    localparam logic [1:0] CFG_DIGITS_HI = 2'd2;

    typedef logic [15:0][7:0] t_codes;

    typedef struct packed {
        logic start;
        logic chk_step;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic chk_done;
        logic base_bad;
        logic div_final;
        logic out_free;
        logic neg;
        logic cnt_one;
    } t_sts;

endpackage

// ----- rtl/signed_int_to_radix_digits.sv -----
// Signed 32-bit value to text in a configured radix, most significant first.
// An alphabet check over MAX_RADIX code slots, then a restoring division per digit
// (4 quotient bits a cycle), then one character per cycle while i_stall is low.
// Reset (synchronous, active low) clears configuration, control and output valid.
module signed_int_to_radix_digits #(
    parameter int MAX_RADIX = sird_pkg::DEF_MAX_RADIX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_char_code,
    output logic               o_last
);
    import sird_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sird_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sird_dp #(
        .MAX_RADIX (MAX_RADIX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

// ----- rtl/sird_dp.sv -----
// Datapath: configuration registers, alphabet check, 4-bit/cycle divider,
// digit stack and output register. Depends on sird_pkg and the assert header.
`include "signed_int_to_radix_digits_assert.svh"

module sird_dp #(
    parameter int MAX_RADIX = sird_pkg::DEF_MAX_RADIX
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_data,
    input  logic [31:0]      i_value,
    input  sird_pkg::t_cmd   i_cmd,
    output sird_pkg::t_sts   o_sts,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_char_code,
    output logic             o_last
);
    import sird_pkg::*;

    logic [4:0]           r_radix;
    logic [63:0]          r_digits_lo;
    logic [63:0]          r_digits_hi;
    logic [31:0]          r_mag, n_mag;
    logic [3:0]           r_rem, n_rem;
    logic [DIV_SW-1:0]    r_step;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [3:0]           r_k;
    logic                 r_bad;
    logic [3:0]           r_stack [MAX_DIGITS];
    logic                 r_ovalid;
    logic [7:0]           r_ochar;
    logic                 r_olast;

    t_codes               codes;
    logic [4:0]           eff_radix;
    logic [7:0]           cur_code;
    logic                 dup;
    logic                 bad_now;
    logic [STACK_AW-1:0]  top_idx;
    logic                 div_last;
    logic                 out_free;

    assign codes     = {r_digits_hi, r_digits_lo};
    assign eff_radix = (r_radix > 5'(MAX_RADIX)) ? 5'(MAX_RADIX) : r_radix;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= '0;
            r_digits_lo <= '0;
            r_digits_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIX:     r_radix     <= i_cfg_data[4:0];
                CFG_DIGITS_LO: r_digits_lo <= i_cfg_data;
                CFG_DIGITS_HI: r_digits_hi <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // alphabet check, one digit per cycle against every later digit
    assign cur_code = codes[r_k];
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < 16; j++) begin
            if ((4'(j) > r_k) && (5'(j) < eff_radix) && (codes[j] == cur_code))
                dup = 1'b1;
        end
        bad_now = (eff_radix < 5'd2) ||
                  (({1'b0, r_k} < eff_radix) &&
                   ((cur_code == 8'h00) || (cur_code == CHAR_PLUS) ||
                    (cur_code == CHAR_MINUS) || dup));
    end

    // four restoring division steps; quotient bits shift in from the bottom
    always_comb begin
        logic [4:0] t;
        n_rem = r_rem;
        n_mag = r_mag;
        t     = '0;
        for (int b = 0; b < 4; b++) begin
            t     = {n_rem, n_mag[31]};
            n_mag = {n_mag[30:0], 1'b0};
            if (t >= eff_radix) begin
                n_rem    = 4'(t - eff_radix);
                n_mag[0] = 1'b1;
            end else begin
                n_rem = t[3:0];
            end
        end
    end

    assign div_last = (r_step == DIV_SW'(DIV_STEPS - 1));
    assign top_idx  = r_cnt[STACK_AW-1:0] - STACK_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag  <= '0;
            r_neg  <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_step <= '0;
            r_k    <= '0;
            r_bad  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_neg  <= i_value[31];
                r_mag  <= i_value[31] ? (32'd0 - i_value) : i_value;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_step <= '0;
                r_k    <= '0;
                r_bad  <= 1'b0;
            end
            if (i_cmd.chk_step) begin
                r_k   <= r_k + 4'd1;
                r_bad <= r_bad | bad_now;
            end
            if (i_cmd.div_step) begin
                r_mag  <= n_mag;
                r_step <= r_step + DIV_SW'(1);
                r_rem  <= div_last ? 4'd0 : n_rem;
                if (div_last && (r_cnt < CNT_W'(MAX_DIGITS)))
                    r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.emit_digit)
                r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && div_last && (r_cnt < CNT_W'(MAX_DIGITS)))
            r_stack[r_cnt[STACK_AW-1:0]] <= n_rem;
    end

    // output register
    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_ochar <= CHAR_MINUS;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_ochar <= codes[r_stack[top_idx]];
            r_olast <= (r_cnt == CNT_W'(1));
        end
    end

    assign o_valid     = r_ovalid;
    assign o_char_code = r_ochar;
    assign o_last      = r_olast;

    assign o_sts.chk_done  = (r_k == 4'(MAX_RADIX - 1));
    assign o_sts.base_bad  = r_bad | bad_now;
    assign o_sts.div_final = div_last && (n_mag == 32'd0);
    assign o_sts.out_free  = out_free;
    assign o_sts.neg       = r_neg;
    assign o_sts.cnt_one   = (r_cnt == CNT_W'(1));

    `SIRD_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_DIGITS))
    `SIRD_ASSERT_NOW(a_pop_nonempty, i_cmd.emit_digit, r_cnt != '0)
    `SIRD_ASSERT_NOW(a_rem_below_radix, i_cmd.div_step, {1'b0, r_rem} < eff_radix)
    `SIRD_ASSERT_NEXT(a_final_marks_last, i_cmd.emit_digit && (r_cnt == CNT_W'(1)),
                      r_ovalid && r_olast)

endmodule

// ----- rtl/sird_ctrl.sv -----
// Controller state machine: check, divide, emit sign, emit digits.
// Depends on sird_pkg; drives the datapath through t_cmd.
module sird_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sird_pkg::t_sts  i_sts,
    output sird_pkg::t_cmd  o_cmd
);
    import sird_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.chk_step = 1'b1;
                if (i_sts.chk_done)
                    n_state = i_sts.base_bad ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_final)
                    n_state = i_sts.neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.cnt_one)
                        n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
